// File: hw/rtl/hrrs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the Hill reaction relaxation step.
// Used by the top level and the port checker; depends on nothing.
package hrrs_pkg;

    localparam int MAX_HILL_ORDER_DEF = 8;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int DATA_W      = 32;
    localparam int FACT_W      = 17;
    localparam int FACT_SHIFT  = 16;
    localparam int IN_HILL_W   = 4;
    // Wide enough for a normalized Hill order up to 16.
    localparam int HILL_W      = 5;
    localparam int KIND_W      = 3;
    localparam int S_TDATA_W   = 296;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 1;
    localparam int DIV_BPS     = 2;
    localparam int MAG_W       = 34;
    localparam int DELTA_W     = 35;

    localparam logic [FACT_W-1:0] FACTOR_ONE = 17'h10000;
    localparam logic [DATA_W-1:0] SAT32      = 32'hFFFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_SINGLE  = 3'd0,
        KIND_ACT     = 3'd1,
        KIND_INH     = 3'd2,
        KIND_ACT_MOD = 3'd3,
        KIND_INH_MOD = 3'd4
    } t_kind;

    typedef struct packed {
        logic [DATA_W-1:0] prev;
        logic [DATA_W-1:0] base;
        logic [FACT_W-1:0] rise;
        logic [FACT_W-1:0] fall;
        t_kind             kind;
        logic [HILL_W-1:0] n;
        logic [DATA_W-1:0] lig;
        logic [DATA_W-1:0] ka;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] h;
        logic [DATA_W-1:0] kh;
        logic [DATA_W-1:0] qmod;
        logic              zsum;
        logic [DATA_W-1:0] cinf;
        logic              dneg;
        logic [MAG_W-1:0]  dabs;
        logic [FACT_W-1:0] fac;
        logic [MAG_W-1:0]  mag;
    } t_ctx;

    // Clamp a wide unsigned value to the 32-bit range.
    function automatic logic [DATA_W-1:0] sat32(input logic [63:0] v);
        return (|v[63:DATA_W]) ? SAT32 : v[DATA_W-1:0];
    endfunction

    // Undefined kind codes fall back to the single-substrate form.
    function automatic t_kind norm_kind(input logic [KIND_W-1:0] k);
        t_kind r;
        case (k)
            KIND_ACT:     r = KIND_ACT;
            KIND_INH:     r = KIND_INH;
            KIND_ACT_MOD: r = KIND_ACT_MOD;
            KIND_INH_MOD: r = KIND_INH_MOD;
            default:      r = KIND_SINGLE;
        endcase
        return r;
    endfunction

    function automatic logic kind_uses_mod(input t_kind k);
        return (k == KIND_ACT_MOD) || (k == KIND_INH_MOD);
    endfunction

    function automatic logic kind_inhibits(input t_kind k);
        return (k == KIND_INH) || (k == KIND_INH_MOD);
    endfunction

endpackage

// File: hw/rtl/hrrs_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, BPS quotient bits per stage, with a side payload.
// Generic in widths; used twice by the top level. Needs no package.
module hrrs_div_pipe #(
    parameter int DVD_W  = 48,
    parameter int DVS_W  = 33,
    parameter int BPS    = 2,
    parameter int SIDE_W = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_vld,
    input  logic [DVD_W-1:0]                            i_dvd,
    input  logic [DVS_W-1:0]                            i_dvs,
    input  logic [SIDE_W-1:0]                           i_side,
    output logic                                        o_vld,
    output logic [((DVD_W + BPS - 1) / BPS) * BPS-1:0]  o_quo,
    output logic [SIDE_W-1:0]                           o_side
);

    localparam int NSTG = (DVD_W + BPS - 1) / BPS;
    localparam int QW   = NSTG * BPS;
    localparam int RW   = DVS_W + 1;

    logic              r_vld  [NSTG];
    logic [RW-1:0]     r_rem  [NSTG];
    logic [QW-1:0]     r_dq   [NSTG];
    logic [DVS_W-1:0]  r_dvs  [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    // The dividend shifts out of the top of dq while quotient bits enter at the bottom.
    function automatic logic [RW+QW-1:0] div_step(input logic [RW-1:0] rem,
                                                  input logic [QW-1:0] dq,
                                                  input logic [DVS_W-1:0] dvs);
        logic [RW-1:0] t;
        logic [RW-1:0] rr;
        logic [QW-1:0] qq;
        rr = rem;
        qq = dq;
        for (int b = 0; b < BPS; b++) begin
            t  = {rr[RW-2:0], qq[QW-1]};
            qq = {qq[QW-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                rr    = t - {1'b0, dvs};
                qq[0] = 1'b1;
            end else begin
                rr = t;
            end
        end
        return {rr, qq};
    endfunction

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic              w_vld;
        logic [RW-1:0]     w_rem;
        logic [QW-1:0]     w_dq;
        logic [DVS_W-1:0]  w_dvs;
        logic [SIDE_W-1:0] w_side;
        logic [RW+QW-1:0]  w_nxt;

        if (g == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = '0;
            assign w_dq   = QW'(i_dvd);
            assign w_dvs  = i_dvs;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_dq   = r_dq[g-1];
            assign w_dvs  = r_dvs[g-1];
            assign w_side = r_side[g-1];
        end

        assign w_nxt = div_step(w_rem, w_dq, w_dvs);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_nxt[RW+QW-1:QW];
                r_dq[g]   <= w_nxt[QW-1:0];
                r_dvs[g]  <= w_dvs;
                r_side[g] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_quo  = r_dq[NSTG-1];
    assign o_side = r_side[NSTG-1];

endmodule

// File: hw/rtl/hill_reaction_relaxation_step.sv
`timescale 1ns / 1ps
// Top level of the Hill reaction relaxation step: a stateless deep pipeline.
// Depends on hrrs_pkg and hrrs_div_pipe.

// One item per cycle while the output is not stalled: each input item carries the
// concentrations and constants of one signaling reaction, and one result item comes
// back with the relaxed product concentration (tdata) and a flag (tuser) that marks a
// result that went negative and was forced to zero. The block keeps no state between
// items, so items of different reactions may be interleaved freely. Each of the two
// pipelined dividers (modifier over Kmod, and the Hill fraction or h/KA) has
// NSTG = ceil((32 + FRAC_BITS) / 2) stages. The whole pipeline advances together
// whenever the output register is empty or being taken, so a stalled result holds
// every stage.
module hill_reaction_relaxation_step #(
    parameter int MAX_HILL_ORDER = hrrs_pkg::MAX_HILL_ORDER_DEF,
    parameter int FRAC_BITS      = hrrs_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // From bit 0 up: prev_conc 32, reagent_conc 32, ligand_conc 32, modifier_conc 32,
    // dissoc_const 32, hill_order 4, mod_const 32, gain_value 32, baseline_value 32,
    // rise_factor 17, fall_factor 17, two zero pad bits.
    input  logic [hrrs_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // kind 3.
    input  logic [hrrs_pkg::S_TUSER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // new_conc 32.
    output logic [hrrs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // negative_error 1.
    output logic [hrrs_pkg::M_TUSER_W-1:0]  o_m_tuser
);

    localparam int DW     = hrrs_pkg::DATA_W;
    localparam int DVD_W  = DW + FRAC_BITS;
    localparam int DVS_W  = DW + 1;
    localparam int BPS    = hrrs_pkg::DIV_BPS;
    localparam int QW     = ((DVD_W + BPS - 1) / BPS) * BPS;
    localparam int ONE_W  = FRAC_BITS + 1;
    localparam int SIDE_W = $bits(hrrs_pkg::t_ctx);
    localparam int HW     = hrrs_pkg::HILL_W;
    localparam int MW     = hrrs_pkg::MAG_W;
    localparam int XW     = hrrs_pkg::DELTA_W;
    localparam int FW     = hrrs_pkg::FACT_W;
    localparam int PW     = MW + FW;
    localparam logic [ONE_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Whole-pipeline advance: the output register is free or is being taken.
    logic w_adv;
    logic r_out_v;
    assign w_adv      = !r_out_v || i_m_tready;
    assign o_s_tready = w_adv;

    // Input field slices.
    logic [DW-1:0]                    w_in_prev, w_in_reag, w_in_lig, w_in_modc, w_in_ka;
    logic [DW-1:0]                    w_in_kmod, w_in_gain, w_in_base;
    logic [hrrs_pkg::IN_HILL_W-1:0]   w_in_hill;
    logic [FW-1:0]                    w_in_rise, w_in_fall;

    assign w_in_prev = i_s_tdata[31:0];
    assign w_in_reag = i_s_tdata[63:32];
    assign w_in_lig  = i_s_tdata[95:64];
    assign w_in_modc = i_s_tdata[127:96];
    assign w_in_ka   = i_s_tdata[159:128];
    assign w_in_hill = i_s_tdata[163:160];
    assign w_in_kmod = i_s_tdata[195:164];
    assign w_in_gain = i_s_tdata[227:196];
    assign w_in_base = i_s_tdata[259:228];
    assign w_in_rise = i_s_tdata[276:260];
    assign w_in_fall = i_s_tdata[293:277];

    // Stage 0: register the item, clamp the factors and the Hill order, form reagent*gain.
    hrrs_pkg::t_ctx   n_s0, r_s0;
    logic [DVD_W-1:0] n_s0_dvd, r_s0_dvd;
    logic [DVS_W-1:0] n_s0_dvs, r_s0_dvs;
    logic             r_s0_v;
    logic [63:0]      w_s0_prod;

    assign w_s0_prod = 64'(w_in_reag) * 64'(w_in_gain);

    always_comb begin
        n_s0      = '0;
        n_s0.prev = w_in_prev;
        n_s0.base = w_in_base;
        n_s0.rise = (w_in_rise > hrrs_pkg::FACTOR_ONE) ? hrrs_pkg::FACTOR_ONE : w_in_rise;
        n_s0.fall = (w_in_fall > hrrs_pkg::FACTOR_ONE) ? hrrs_pkg::FACTOR_ONE : w_in_fall;
        n_s0.kind = hrrs_pkg::norm_kind(i_s_tuser);
        if (w_in_hill == '0) begin
            n_s0.n = HW'(1);
        end else if ({1'b0, w_in_hill} > HW'(MAX_HILL_ORDER)) begin
            n_s0.n = HW'(MAX_HILL_ORDER);
        end else begin
            n_s0.n = {1'b0, w_in_hill};
        end
        n_s0.lig  = w_in_lig;
        n_s0.ka   = w_in_ka;
        n_s0.s    = hrrs_pkg::sat32(w_s0_prod >> FRAC_BITS);
        n_s0_dvd  = {w_in_modc, {FRAC_BITS{1'b0}}};
        n_s0_dvs  = {1'b0, w_in_kmod};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_adv) begin
            r_s0_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0     <= n_s0;
            r_s0_dvd <= n_s0_dvd;
            r_s0_dvs <= n_s0_dvs;
        end
    end

    // Modifier over Kmod. A zero Kmod yields an all-ones quotient, which saturates.
    logic              w_d1_v;
    logic [QW-1:0]     w_d1_quo;
    logic [SIDE_W-1:0] w_d1_side;

    hrrs_div_pipe #(
        .DVD_W  (DVD_W),
        .DVS_W  (DVS_W),
        .BPS    (BPS),
        .SIDE_W (SIDE_W)
    ) u_div_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_s0_v),
        .i_dvd   (r_s0_dvd),
        .i_dvs   (r_s0_dvs),
        .i_side  (r_s0),
        .o_vld   (w_d1_v),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    // Power chain: stage 0 seeds h and kh, each later stage multiplies once more while
    // its index is below the Hill order.
    hrrs_pkg::t_ctx r_pw_c [MAX_HILL_ORDER];
    logic           r_pw_v [MAX_HILL_ORDER];
    hrrs_pkg::t_ctx n_pw0;

    always_comb begin
        n_pw0      = hrrs_pkg::t_ctx'(w_d1_side);
        n_pw0.h    = n_pw0.lig;
        n_pw0.kh   = n_pw0.ka;
        n_pw0.qmod = hrrs_pkg::sat32(64'(w_d1_quo));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_pw_v[0] <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pw_c[0] <= n_pw0;
        end
    end

    for (genvar g = 1; g < MAX_HILL_ORDER; g++) begin : g_pow
        logic [63:0]    w_ph, w_pk;
        hrrs_pkg::t_ctx n_pw;

        assign w_ph = 64'(r_pw_c[g-1].h) * 64'(r_pw_c[g-1].lig);
        assign w_pk = 64'(r_pw_c[g-1].kh) * 64'(r_pw_c[g-1].ka);

        always_comb begin
            n_pw = r_pw_c[g-1];
            if (HW'(g) < r_pw_c[g-1].n) begin
                n_pw.h  = hrrs_pkg::sat32(w_ph >> FRAC_BITS);
                n_pw.kh = hrrs_pkg::sat32(w_pk >> FRAC_BITS);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pw_v[g] <= 1'b0;
            end else if (w_adv) begin
                r_pw_v[g] <= r_pw_v[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pw_c[g] <= n_pw;
            end
        end
    end

    // Modifier scaling of h for the modifier kinds.
    hrrs_pkg::t_ctx n_sc, r_sc;
    logic           r_sc_v;
    logic [63:0]    w_sc_prod;

    assign w_sc_prod = 64'(r_pw_c[MAX_HILL_ORDER-1].h) * 64'(r_pw_c[MAX_HILL_ORDER-1].qmod);

    always_comb begin
        n_sc = r_pw_c[MAX_HILL_ORDER-1];
        if (hrrs_pkg::kind_uses_mod(n_sc.kind)) begin
            n_sc.h = hrrs_pkg::sat32(w_sc_prod >> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_v <= 1'b0;
        end else if (w_adv) begin
            r_sc_v <= r_pw_v[MAX_HILL_ORDER-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sc <= n_sc;
        end
    end

    // Divider operands: h over KA for the single-substrate kind, else h over h + KA^n.
    hrrs_pkg::t_ctx   n_pr, r_pr;
    logic [DVD_W-1:0] n_pr_dvd, r_pr_dvd;
    logic [DVS_W-1:0] n_pr_dvs, r_pr_dvs;
    logic             r_pr_v;
    logic [DVS_W-1:0] w_sum;
    logic             w_single;

    assign w_sum    = {1'b0, r_sc.h} + {1'b0, r_sc.kh};
    assign w_single = (r_sc.kind == hrrs_pkg::KIND_SINGLE);

    always_comb begin
        n_pr      = r_sc;
        n_pr.zsum = !w_single && (w_sum == '0);
        n_pr_dvd  = {r_sc.h, {FRAC_BITS{1'b0}}};
        n_pr_dvs  = w_single ? {1'b0, r_sc.ka} : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_v <= 1'b0;
        end else if (w_adv) begin
            r_pr_v <= r_sc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pr     <= n_pr;
            r_pr_dvd <= n_pr_dvd;
            r_pr_dvs <= n_pr_dvs;
        end
    end

    logic              w_d2_v;
    logic [QW-1:0]     w_d2_quo;
    logic [SIDE_W-1:0] w_d2_side;

    hrrs_div_pipe #(
        .DVD_W  (DVD_W),
        .DVS_W  (DVS_W),
        .BPS    (BPS),
        .SIDE_W (SIDE_W)
    ) u_div_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_pr_v),
        .i_dvd   (r_pr_dvd),
        .i_dvs   (r_pr_dvs),
        .i_side  (r_pr),
        .o_vld   (w_d2_v),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    // Steady state: the quotient itself for the single-substrate kind, else
    // gain*reagent times the clamped fraction or its complement.
    hrrs_pkg::t_ctx   w_d2_ctx, n_ci, r_ci;
    logic             r_ci_v;
    logic [ONE_W-1:0] w_frac;
    logic [63:0]      w_ci_prod;

    assign w_d2_ctx  = hrrs_pkg::t_ctx'(w_d2_side);
    assign w_ci_prod = 64'(w_d2_ctx.s) * 64'(w_frac);

    always_comb begin
        if (w_d2_quo > QW'(ONE)) begin
            w_frac = ONE;
        end else begin
            w_frac = w_d2_quo[ONE_W-1:0];
        end
        if (w_d2_ctx.zsum) begin
            w_frac = '0;
        end
        if (hrrs_pkg::kind_inhibits(w_d2_ctx.kind)) begin
            w_frac = ONE - w_frac;
        end
        n_ci = w_d2_ctx;
        if (w_d2_ctx.kind == hrrs_pkg::KIND_SINGLE) begin
            n_ci.cinf = hrrs_pkg::sat32(64'(w_d2_quo));
        end else begin
            n_ci.cinf = hrrs_pkg::sat32(w_ci_prod >> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci_v <= 1'b0;
        end else if (w_adv) begin
            r_ci_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ci <= n_ci;
        end
    end

    // Signed change toward baseline plus steady state, split into sign and magnitude.
    hrrs_pkg::t_ctx n_de, r_de;
    logic           r_de_v;
    logic [XW-1:0]  w_delta;
    logic [XW-1:0]  w_ndelta;

    assign w_delta  = XW'(r_ci.cinf) + XW'(r_ci.base) - XW'(r_ci.prev);
    assign w_ndelta = -w_delta;

    always_comb begin
        n_de      = r_ci;
        n_de.dneg = w_delta[XW-1];
        n_de.dabs = w_delta[XW-1] ? w_ndelta[MW-1:0] : w_delta[MW-1:0];
        n_de.fac  = w_delta[XW-1] ? r_ci.fall : r_ci.rise;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_de_v <= 1'b0;
        end else if (w_adv) begin
            r_de_v <= r_ci_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_de <= n_de;
        end
    end

    // Step size: magnitude times the relaxation factor, Q1.16.
    hrrs_pkg::t_ctx n_mg, r_mg;
    logic           r_mg_v;
    logic [PW-1:0]  w_mg_prod;

    assign w_mg_prod = PW'(r_de.dabs) * PW'(r_de.fac);

    always_comb begin
        n_mg     = r_de;
        n_mg.mag = w_mg_prod[hrrs_pkg::FACT_SHIFT +: MW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mg_v <= 1'b0;
        end else if (w_adv) begin
            r_mg_v <= r_de_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mg <= n_mg;
        end
    end

    // Output register: apply the step, saturate upward, flag and zero a negative result.
    logic [DW-1:0] n_out_conc, r_out_conc;
    logic          n_out_err, r_out_err;
    logic [XW-1:0] w_up;

    assign w_up = XW'(r_mg.prev) + XW'(r_mg.mag);

    always_comb begin
        n_out_err = 1'b0;
        if (!r_mg.dneg) begin
            n_out_conc = (|w_up[XW-1:DW]) ? hrrs_pkg::SAT32 : w_up[DW-1:0];
        end else if (MW'(r_mg.prev) < r_mg.mag) begin
            n_out_conc = '0;
            n_out_err  = 1'b1;
        end else begin
            n_out_conc = r_mg.prev - r_mg.mag[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_mg_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_conc <= n_out_conc;
            r_out_err  <= n_out_err;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_conc;
    assign o_m_tuser  = r_out_err;

endmodule

// File: hw/rtl/hrrs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Hill reaction relaxation step, bound to the top level.
// Depends on hrrs_pkg for port widths.
module hrrs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [hrrs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic [hrrs_pkg::M_TUSER_W-1:0]  o_m_tuser
);

    // A held result keeps its value until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("held result changed");

    // Input back-pressure only comes from a stalled result.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output stall");

    // A negative result is reported as zero.
    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("negative flag with nonzero concentration");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Nothing comes out straight after reset with no input offered.
    a_no_invent: assert property (@(posedge i_clk)
        !i_rst_n ##1 !i_s_tvalid |=> !o_m_tvalid)
        else $error("result without input");

endmodule

bind hill_reaction_relaxation_step hrrs_checker u_hrrs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
